FILE: hw/rtl/mouse_packet_event_decoder_core_macros.svh
// assertion macros for the mouse packet event decoder
`ifndef MOUSE_PACKET_EVENT_DECODER_CORE_MACROS_SVH
`define MOUSE_PACKET_EVENT_DECODER_CORE_MACROS_SVH

// property must hold at every clock edge out of reset
`define MPD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("mpd assertion failed");

// condition must never be seen out of reset
`define MPD_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("mpd forbidden condition seen");

`endif

FILE: hw/rtl/mpd_pkg.sv
// shared types and constants of the mouse packet event decoder
package mpd_pkg;

	localparam int unsigned MaxEvents = 3;

	// header byte bit positions
	localparam int unsigned HdrSyncBit  = 3;
	localparam int unsigned HdrXSignBit = 4;
	localparam int unsigned HdrYSignBit = 5;
	localparam int unsigned HdrXOvfBit  = 6;
	localparam int unsigned HdrYOvfBit  = 7;

	localparam logic [8:0] MoveSpan = 9'h100;

	typedef enum logic [2:0] {
		KIND_MIDDLE = 3'd0,
		KIND_RIGHT  = 3'd1,
		KIND_LEFT   = 3'd2,
		KIND_XMOVE  = 3'd3,
		KIND_YMOVE  = 3'd4
	} event_kind_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_X      = 2'd1,
		PH_Y      = 2'd2
	} phase_t;

	typedef struct packed {
		event_kind_t kind;
		logic        released;
		logic        negative;
		logic [8:0]  amount;
	} event_t;

	// events caused by one accepted word, in delivery order
	typedef struct packed {
		logic [1:0]   n;
		event_t [2:0] ev;
	} dec_list_t;

endpackage

FILE: hw/rtl/mpd_decode.sv
// packet phase tracking and per-word event decode
`include "mouse_packet_event_decoder_core_macros.svh"

module mpd_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        rx_byte,
	output mpd_pkg::dec_list_t dec
);

	mpd_pkg::phase_t phase_q, phase_d;
	logic [2:0]      button_q, button_d;
	logic [1:0]      signs_q, signs_d;
	logic            hdr_ok;
	logic [2:0]      changed;
	logic            hdr_take;

	function automatic mpd_pkg::event_t make_move(mpd_pkg::event_kind_t kind, logic neg,
			logic [7:0] b);
		mpd_pkg::event_t e;
		e.kind     = kind;
		e.released = 1'b0;
		e.negative = neg;
		e.amount   = neg ? (mpd_pkg::MoveSpan - {1'b0, b}) : {1'b0, b};
		return e;
	endfunction

	assign hdr_ok = rx_byte[mpd_pkg::HdrSyncBit] && !rx_byte[mpd_pkg::HdrXOvfBit]
		&& !rx_byte[mpd_pkg::HdrYOvfBit];
	assign changed = rx_byte[2:0] ^ button_q;
	assign hdr_take = accept && phase_q != mpd_pkg::PH_X && phase_q != mpd_pkg::PH_Y
		&& hdr_ok;

	// next state
	always_comb begin
		phase_d  = phase_q;
		button_d = button_q;
		signs_d  = signs_q;
		if (accept) begin
			unique case (phase_q)
				mpd_pkg::PH_X: phase_d = mpd_pkg::PH_Y;
				mpd_pkg::PH_Y: phase_d = mpd_pkg::PH_HEADER;
				default: begin
					if (hdr_ok) begin
						phase_d  = mpd_pkg::PH_X;
						button_d = rx_byte[2:0];
						signs_d  = {rx_byte[mpd_pkg::HdrYSignBit], rx_byte[mpd_pkg::HdrXSignBit]};
					end else begin
						phase_d = mpd_pkg::PH_HEADER;
					end
				end
			endcase
		end
	end

	// event list for the current word
	always_comb begin
		dec = '0;
		unique case (phase_q)
			mpd_pkg::PH_X: begin
				dec.ev[0] = make_move(mpd_pkg::KIND_XMOVE, signs_q[0], rx_byte);
				dec.n     = 2'd1;
			end
			mpd_pkg::PH_Y: begin
				dec.ev[0] = make_move(mpd_pkg::KIND_YMOVE, signs_q[1], rx_byte);
				dec.n     = 2'd1;
			end
			default: begin
				if (hdr_ok) begin
					// middle, right, left
					for (int i = 0; i < mpd_pkg::MaxEvents; i++) begin
						if (changed[2 - i]) begin
							dec.ev[dec.n].kind     = mpd_pkg::event_kind_t'(3'(i));
							dec.ev[dec.n].released = !rx_byte[2 - i];
							dec.ev[dec.n].negative = 1'b0;
							dec.ev[dec.n].amount   = '0;
							dec.n                  = dec.n + 2'd1;
						end
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= mpd_pkg::PH_HEADER;
			button_q <= '0;
			signs_q  <= '0;
		end else begin
			phase_q  <= phase_d;
			button_q <= button_d;
			signs_q  <= signs_d;
		end
	end

	`MPD_ASSERT(a_move_single, accept && phase_q != mpd_pkg::PH_HEADER |-> dec.n == 2'd1)
	`MPD_ASSERT(a_y_ends_packet, accept && phase_q == mpd_pkg::PH_Y |=> phase_q == mpd_pkg::PH_HEADER)
	`MPD_ASSERT(a_hdr_latch, hdr_take |=> phase_q == mpd_pkg::PH_X && button_q == $past(rx_byte[2:0]))

endmodule

FILE: hw/rtl/mpd_emit.sv
// event list holding register and result word register
`include "mouse_packet_event_decoder_core_macros.svh"

module mpd_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  mpd_pkg::dec_list_t dec,
	output logic               list_full,
	input  logic               out_stall,
	output logic               out_valid,
	output mpd_pkg::event_t    out_ev,
	output logic               out_last
);

	mpd_pkg::event_t [2:0] ev_q;
	logic [1:0]            cnt_q;
	logic                  out_valid_q;
	mpd_pkg::event_t       out_ev_q;
	logic                  out_last_q;
	logic                  out_free;
	logic                  pop;

	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = out_free && (cnt_q != 2'd0);
	assign list_full = !((cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_free));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cnt_q <= dec.n;
			end else if (pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ev_q <= dec.ev;
		end else if (pop) begin
			ev_q[0] <= ev_q[1];
			ev_q[1] <= ev_q[2];
		end
		if (pop) begin
			out_ev_q   <= ev_q[0];
			out_last_q <= (cnt_q == 2'd1);
		end
	end

	assign out_valid = out_valid_q;
	assign out_ev    = out_ev_q;
	assign out_last  = out_last_q;

	`MPD_ASSERT(a_load_count, load && dec.n != 2'd0 |=> cnt_q == $past(dec.n))
	`MPD_ASSERT(a_pop_fills, cnt_q != 2'd0 && out_free |=> out_valid_q)
	`MPD_NEVER(a_orphan_word, out_valid_q && !out_last_q && cnt_q == 2'd0)

endmodule

FILE: hw/rtl/mouse_packet_event_decoder_core.sv
// mouse packet event decoder top level
// Takes mouse link bytes one word at a time and decodes three-byte packets
// (header, x byte, y byte) into button and move events, one event per output
// word, with last marking the final event caused by an input byte. An x or y
// byte gives one move event and can be accepted every cycle while the output
// is not stalled. A valid header gives one event per changed button (middle,
// right, left), so it holds the event list until each of its events has moved
// to the output register; a header that is invalid or changes no button gives
// no word. The next byte is accepted in the cycle the last queued event moves
// to the output register, so the rate is set by that single-word output path.
// Events go from the event list register to the output word register.
module mouse_packet_event_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] event_kind,
	output logic       released,
	output logic       negative,
	output logic [8:0] amount,
	output logic       last
);

	mpd_pkg::dec_list_t dec;
	mpd_pkg::event_t    out_ev;
	logic               list_full;
	logic               accept;

	assign in_stall = list_full;
	assign accept   = in_valid && !list_full;

	mpd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.dec     (dec)
	);

	mpd_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.dec       (dec),
		.list_full (list_full),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_ev    (out_ev),
		.out_last  (last)
	);

	assign event_kind = out_ev.kind;
	assign released   = out_ev.released;
	assign negative   = out_ev.negative;
	assign amount     = out_ev.amount;

endmodule
